// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concurrent check failed");
// Check that cons holds in the cycle after ante.
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concurrent check failed");
`else
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/arc_pkg.sv =====
// ============================================================================
// arc_pkg
// Shared types and codes of the ARP responder and address cache.
// ============================================================================
package arc_pkg;

    // Operation field codes
    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // ARP opcodes
    localparam logic [15:0] OPCODE_REQUEST = 16'd1;
    localparam logic [15:0] OPCODE_REPLY   = 16'd2;

    // Register selects (paddr bit 3)
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // Command queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_REPLY    = 3'd0,
        KIND_QUERY    = 3'd1,
        KIND_HIT      = 3'd2,
        KIND_WAITING  = 3'd3,
        KIND_RESOLVED = 3'd4,
        KIND_FULL     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        CMD_REPLY   = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_LOOKUP  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] ip;
        logic [47:0] mac;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } front_status_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] ip;
        logic [47:0] mac;
    } result_t;

endpackage

// ===== rtl/arp_responder_and_cache_core.sv =====
// ============================================================================
// arp_responder_and_cache_core
// A request is taken when start is high and busy is low; busy rises only
// while the two-deep command queue is full. An ARP request for own_ip is
// answered via the command queue and the result register when nothing is
// queued ahead of it. An ARP reply or a lookup scans the address table
// through one comparator at one entry per clock, up to the fill count or the
// first match, before its result; the next queued command starts after it.
// Requests that produce nothing (other opcodes, requests for another
// address) are dropped at the input. Each result is shown for exactly one
// cycle on result_valid and cannot be held off, so the receiver must take it
// then. Registers sit at byte offsets 0 (own_ip) and 8 (own_mac); the offset
// within a register is not decoded. They are to be written only while the
// block is idle; the block itself does not enforce it.
// ============================================================================
`include "assert_macros.svh"

module arp_responder_and_cache_core #(
    parameter int TABLE_ENTRIES = 16,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] arp_opcode,
    input  logic [31:0] sender_ip,
    input  logic [47:0] sender_mac,
    input  logic [31:0] target_ip,
    input  logic [31:0] lookup_ip,
    output logic        result_valid,
    output logic [2:0]  result_kind,
    output logic [31:0] peer_ip,
    output logic [47:0] peer_mac,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import arc_pkg::*;

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_ENTRIES);

    logic [31:0]      own_ip_reg;
    logic [47:0]      own_mac_reg;
    logic             cfg_write;
    q_head_t          q_head;
    logic             q_pop;
    front_status_t    front_stat;
    result_t          res;
    logic [CNT_W-1:0] fill_count;
    logic             is_query;
    logic             is_blank_mac;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= 32'd0;
            own_mac_reg <= 48'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3])
                REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (paddr[3])
            REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            default:     prdata = 64'd0;
        endcase
    end

    arc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .arp_opcode (arp_opcode),
        .sender_ip  (sender_ip),
        .sender_mac (sender_mac),
        .target_ip  (target_ip),
        .lookup_ip  (lookup_ip),
        .own_ip     (own_ip_reg),
        .q_pop      (q_pop),
        .q_head     (q_head),
        .status     (front_stat)
    );

    arc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .result     (res),
        .fill_count (fill_count)
    );

    assign result_valid = res.valid;
    assign result_kind  = res.kind;
    assign peer_ip      = res.ip;
    assign peer_mac     = res.mac;

    // Classify the current result for the checks
    assign is_query     = res.valid && (res.kind == KIND_QUERY);
    assign is_blank_mac = res.valid && (res.kind inside {KIND_QUERY, KIND_WAITING, KIND_FULL});

    // Checks
    `ARC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_count <= FILL_MAX)
    `ARC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, front_stat.count != '0)
    `ARC_ASSERT_IMP(a_query_inserts, clk, rst_n, is_query, fill_count == $past(fill_count) + 1'b1)
    `ARC_ASSERT_IMP(a_zero_mac, clk, rst_n, is_blank_mac, res.mac == 48'd0)

endmodule

// ===== rtl/arc_ram.sv =====
// ============================================================================
// arc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module arc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/arc_front.sv =====
// ============================================================================
// arc_front
// Accepts requests, classifies them and queues the ones that need work.
// ============================================================================
module arc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [15:0]            arp_opcode,
    input  logic [31:0]            sender_ip,
    input  logic [47:0]            sender_mac,
    input  logic [31:0]            target_ip,
    input  logic [31:0]            lookup_ip,
    input  logic [31:0]            own_ip,
    input  logic                   q_pop,
    output arc_pkg::q_head_t       q_head,
    output arc_pkg::front_status_t status
);
    import arc_pkg::*;

    q_entry_t          q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              keep;
    logic              push;
    q_entry_t          cls_entry;

    // Classify the incoming request; drop what produces nothing
    always_comb
    begin
        keep      = 1'b0;
        cls_entry = '{cmd: CMD_LOOKUP, ip: lookup_ip, mac: 48'd0};
        case (operation)
            OP_FRAME:
            begin
                case (arp_opcode)
                    OPCODE_REQUEST:
                    begin
                        keep      = (target_ip == own_ip);
                        cls_entry = '{cmd: CMD_REPLY, ip: sender_ip, mac: sender_mac};
                    end
                    OPCODE_REPLY:
                    begin
                        keep      = 1'b1;
                        cls_entry = '{cmd: CMD_RESOLVE, ip: sender_ip, mac: sender_mac};
                    end
                    default:
                    begin
                        keep = 1'b0;
                    end
                endcase
            end
            OP_LOOKUP:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign busy   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign push   = accept && keep;

    // Advance queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_entry;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.entry = q_mem_reg[rd_ptr_reg];
    assign status.count = count_reg;

endmodule

// ===== rtl/arc_back.sv =====
// ============================================================================
// arc_back
// Executes queued commands: scans the address table one entry per cycle,
// updates or inserts entries and issues the result strobe.
// ============================================================================
module arc_back #(
    parameter int TABLE_ENTRIES = 16,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arc_pkg::q_head_t q_head,
    output logic             q_pop,
    output arc_pkg::result_t result,
    output logic [CNT_W-1:0] fill_count
);
    import arc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_ENTRIES);

    state_t                   state_reg, state_next;
    q_entry_t                 cur_reg, cur_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     pend_reg, pend_next;
    logic [TABLE_ENTRIES-1:0] done_reg, done_next;
    result_t                  res_reg, res_next;
    logic                     addr_we;
    logic                     hw_we;
    logic [IDX_W-1:0]         wr_idx;
    logic [47:0]              hw_wdata;
    logic [31:0]              addr_rdata;
    logic [47:0]              hw_rdata;
    logic                     match;
    logic                     no_more;

    // Address and hardware tables, both read at the scan index
    arc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (wr_idx),
        .wdata (cur_reg.ip),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (addr_rdata)
    );

    arc_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_hw_ram (
        .clk   (clk),
        .we    (hw_we),
        .waddr (wr_idx),
        .wdata (hw_wdata),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (hw_rdata)
    );

    // Entries are filled in order, so the used entries are those below the fill count
    assign match   = pend_reg && (addr_rdata == cur_reg.ip);
    assign no_more = (issue_reg >= fill_reg);

    // Sequence one command
    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        fill_next    = fill_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = 1'b0;
        done_next    = done_reg;
        res_next     = res_reg;
        res_next.valid = 1'b0;
        q_pop        = 1'b0;
        addr_we      = 1'b0;
        hw_we        = 1'b0;
        wr_idx       = cmp_idx_reg;
        hw_wdata     = cur_reg.mac;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head.entry;
                    issue_next = '0;
                    if (q_head.entry.cmd == CMD_REPLY)
                    begin
                        res_next = '{valid: 1'b1, kind: KIND_REPLY,
                                     ip: q_head.entry.ip, mac: q_head.entry.mac};
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    // Hit: update on a reply, report on a lookup
                    state_next = ST_IDLE;
                    case (cur_reg.cmd)
                        CMD_RESOLVE:
                        begin
                            hw_we                  = 1'b1;
                            done_next[cmp_idx_reg] = 1'b1;
                            res_next = '{valid: 1'b1, kind: KIND_RESOLVED,
                                         ip: cur_reg.ip, mac: cur_reg.mac};
                        end
                        CMD_LOOKUP:
                        begin
                            if (done_reg[cmp_idx_reg])
                            begin
                                res_next = '{valid: 1'b1, kind: KIND_HIT,
                                             ip: cur_reg.ip, mac: hw_rdata};
                            end
                            else
                            begin
                                res_next = '{valid: 1'b1, kind: KIND_WAITING,
                                             ip: cur_reg.ip, mac: 48'd0};
                            end
                        end
                        default:
                        begin
                            res_next.valid = 1'b0;
                        end
                    endcase
                end
                else if (!no_more)
                begin
                    // Issue the next entry read
                    issue_next   = issue_reg + 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    // Miss: a reply is dropped, a lookup inserts or reports full
                    state_next = ST_IDLE;
                    if (cur_reg.cmd == CMD_LOOKUP)
                    begin
                        if (fill_reg >= FILL_MAX)
                        begin
                            res_next = '{valid: 1'b1, kind: KIND_FULL,
                                         ip: cur_reg.ip, mac: 48'd0};
                        end
                        else
                        begin
                            addr_we           = 1'b1;
                            hw_we             = 1'b1;
                            wr_idx            = fill_reg[IDX_W-1:0];
                            hw_wdata          = 48'd0;
                            done_next[wr_idx] = 1'b0;
                            fill_next         = fill_reg + 1'b1;
                            res_next = '{valid: 1'b1, kind: KIND_QUERY,
                                         ip: cur_reg.ip, mac: 48'd0};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    // Hold the current command and compare index
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    assign result     = res_reg;
    assign fill_count = fill_reg;

endmodule

// ===== tb/arc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// arc_checker
// Watches the request, result and register ports of the ARP responder and
// address cache. It keeps its own copy of the address table and the
// interface registers, works out the answer due for each accepted request,
// and matches every result strobe against the oldest answer still due.
// ============================================================================
module arc_checker #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        operation,
    input  logic [15:0] arp_opcode,
    input  logic [31:0] sender_ip,
    input  logic [47:0] sender_mac,
    input  logic [31:0] target_ip,
    input  logic [31:0] lookup_ip,
    input  logic        result_valid,
    input  logic [2:0]  result_kind,
    input  logic [31:0] peer_ip,
    input  logic [47:0] peer_mac,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);
    import arc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] ip;
        logic [47:0] mac;
    } answer_t;

    // Answers owed by the block, oldest first
    answer_t     due_answers[$];

    // Shadow copy of the address table and the interface registers
    logic [31:0] cache_ip    [ENTRIES];
    logic [47:0] cache_mac   [ENTRIES];
    logic        cache_live  [ENTRIES];
    logic        cache_known [ENTRIES];
    int unsigned cache_fill;
    logic [31:0] host_ip;
    logic [47:0] host_mac;

    // Slot of the live entry holding addr, or -1
    function automatic int find_slot(input logic [31:0] addr);
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_live[i] && cache_ip[i] == addr)
                return i;
        end
        return -1;
    endfunction

    // Update the shadow table for one request and queue the answer it owes
    task automatic predict_request(
        input logic        op,
        input logic [15:0] opc,
        input logic [31:0] sip,
        input logic [47:0] smac,
        input logic [31:0] tip,
        input logic [31:0] lip
    );
        int      slot;
        answer_t ans;
        bit      owes;
        owes = 1'b0;
        ans  = '0;
        if (op == OP_FRAME) begin
            if (opc == OPCODE_REQUEST) begin
                if (tip == host_ip) begin
                    ans  = '{kind: KIND_REPLY, ip: sip, mac: smac};
                    owes = 1'b1;
                end
            end else if (opc == OPCODE_REPLY) begin
                slot = find_slot(sip);
                if (slot >= 0) begin
                    cache_mac[slot]   = smac;
                    cache_known[slot] = 1'b1;
                    ans  = '{kind: KIND_RESOLVED, ip: sip, mac: smac};
                    owes = 1'b1;
                end
            end
        end else begin
            owes = 1'b1;
            slot = find_slot(lip);
            if (slot >= 0) begin
                if (cache_known[slot])
                    ans = '{kind: KIND_HIT, ip: lip, mac: cache_mac[slot]};
                else
                    ans = '{kind: KIND_WAITING, ip: lip, mac: 48'd0};
            end else if (cache_fill >= ENTRIES) begin
                ans = '{kind: KIND_FULL, ip: lip, mac: 48'd0};
            end else begin
                cache_ip[cache_fill]    = lip;
                cache_mac[cache_fill]   = 48'd0;
                cache_live[cache_fill]  = 1'b1;
                cache_known[cache_fill] = 1'b0;
                cache_fill++;
                ans = '{kind: KIND_QUERY, ip: lip, mac: 48'd0};
            end
        end
        if (owes)
            due_answers.push_back(ans);
    endtask

    // Match one result strobe against the oldest answer due
    task automatic match_result();
        answer_t want;
        if (due_answers.size() == 0) begin
            $display("%0t: unexpected result kind %0d ip %h mac %h",
                     $time, result_kind, peer_ip, peer_mac);
            fail_count++;
        end else begin
            want = due_answers.pop_front();
            if (result_kind !== want.kind) begin
                $display("%0t: result_kind expected %0d actual %0d",
                         $time, want.kind, result_kind);
                fail_count++;
            end
            if (peer_ip !== want.ip) begin
                $display("%0t: peer_ip expected %h actual %h", $time, want.ip, peer_ip);
                fail_count++;
            end
            if (peer_mac !== want.mac) begin
                $display("%0t: peer_mac expected %h actual %h", $time, want.mac, peer_mac);
                fail_count++;
            end
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                cache_live[i]  = 1'b0;
                cache_known[i] = 1'b0;
            end
            cache_fill = 0;
            host_ip    = '0;
            host_mac   = '0;
            due_answers.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Results first: a request taken at this edge cannot answer yet
            if (result_valid)
                match_result();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_OWN_IP)
                    host_ip = pwdata[31:0];
                else
                    host_mac = pwdata[47:0];
            end
            if (start && !busy)
                predict_request(operation, arp_opcode, sender_ip, sender_mac,
                                target_ip, lookup_ip);
            outstanding = due_answers.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives the ARP responder and address cache with a directed opening and
// then pool-based random requests under several register settings, with
// random start gaps and drain pauses. A side checker predicts and compares
// every result; this module gives the verdict.
// ============================================================================
module tb;
    import arc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int PHASES      = 5;
    localparam int PER_PHASE   = 108;
    localparam int POOL_SIZE   = 24;
    localparam int SETTLE      = 64;
    localparam int STALL_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] lookup_ip;
    logic        result_valid;
    logic [2:0]  result_kind;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    int          idle_cycles;

    logic [31:0] cfg_ip;
    logic [31:0] addr_pool [POOL_SIZE];

    arp_responder_and_cache_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .arp_opcode(arp_opcode),
        .sender_ip(sender_ip), .sender_mac(sender_mac),
        .target_ip(target_ip), .lookup_ip(lookup_ip),
        .result_valid(result_valid), .result_kind(result_kind),
        .peer_ip(peer_ip), .peer_mac(peer_mac),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    arc_checker #(
        .ENTRIES(ENTRIES)
    ) arc_watch (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .arp_opcode(arp_opcode),
        .sender_ip(sender_ip), .sender_mac(sender_mac),
        .target_ip(target_ip), .lookup_ip(lookup_ip),
        .result_valid(result_valid), .result_kind(result_kind),
        .peer_ip(peer_ip), .peer_mac(peer_mac),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Present one request and hold it until taken; returns at a falling edge
    task automatic send_request(
        input bit          gaps,
        input logic        op,
        input logic [15:0] opc,
        input logic [31:0] sip,
        input logic [47:0] smac,
        input logic [31:0] tip,
        input logic [31:0] lip
    );
        while (gaps && $urandom_range(0, 99) < 31)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        operation  = op;
        arp_opcode = opc;
        sender_ip  = sip;
        sender_mac = smac;
        target_ip  = tip;
        lookup_ip  = lip;
        // busy only moves at rising edges, so it is stable here
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Hold off until every answer is in and the scan has gone quiet
    task automatic drain_results();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Register write with a setup and an access phase; low address bits are left random
    task automatic write_reg(input logic sel, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 3'($urandom_range(0, 7))};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        while (!pready)
            @(negedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly well-formed traffic on a small address pool, some noise
    task automatic send_random(input bit gaps, output bit useful);
        int          r;
        logic [31:0] pick;
        logic [31:0] tip;
        r    = $urandom_range(0, 99);
        pick = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : 32'($urandom);
        useful = 1'b1;
        if (r < 40)
            send_request(gaps, OP_LOOKUP, 16'($urandom), $urandom, rand_mac(),
                         $urandom, pick);
        else if (r < 65)
            send_request(gaps, OP_FRAME, OPCODE_REPLY, pick, rand_mac(),
                         $urandom, $urandom);
        else if (r < 90)
        begin
            tip = $urandom_range(0, 1) ? cfg_ip : 32'($urandom);
            useful = (tip == cfg_ip);
            send_request(gaps, OP_FRAME, OPCODE_REQUEST, $urandom, rand_mac(),
                         tip, $urandom);
        end
        else
        begin
            useful = 1'b0;
            send_request(gaps, OP_FRAME, 16'($urandom), pick, rand_mac(),
                         $urandom, $urandom);
        end
    endtask

    // Opening sequence over each kind of request and each kind of answer but the full-table one
    task automatic run_directed();
        send_request(1'b0, OP_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000);
        send_request(1'b0, OP_LOOKUP, 16'hFFFF, '1, '1, '1, 32'hFFFF_FFFF);
        send_request(1'b0, OP_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000);
        send_request(1'b0, OP_FRAME, OPCODE_REPLY, 32'd0, '1, '1, 32'd0);
        send_request(1'b0, OP_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000);
        // Reply to an entry already resolved overwrites it
        send_request(1'b0, OP_FRAME, OPCODE_REPLY, 32'd0, 48'd0, 32'd0, '1);
        send_request(1'b0, OP_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000);
        send_request(1'b0, OP_FRAME, OPCODE_REPLY, '1, rand_mac(), 32'd0, 32'd0);
        send_request(1'b0, OP_FRAME, OPCODE_REQUEST, '1, '1, cfg_ip, '1);
        send_request(1'b0, OP_FRAME, OPCODE_REQUEST, 32'd0, 48'd0, cfg_ip, 32'd0);
        // Request for another address
        send_request(1'b0, OP_FRAME, OPCODE_REQUEST, '1, '1, ~cfg_ip, '1);
        // Opcodes outside request and reply
        send_request(1'b0, OP_FRAME, 16'd0, 32'd0, '1, cfg_ip, 32'd0);
        send_request(1'b0, OP_FRAME, 16'hFFFF, 32'd0, '1, cfg_ip, 32'd0);
        send_request(1'b0, OP_FRAME, 16'd3, 32'd0, '1, cfg_ip, 32'd0);
        // Reply for an address not in the table
        send_request(1'b0, OP_FRAME, OPCODE_REPLY, 32'h1234_5678, '1, '1, '1);
        // Lookup with all other fields at their top
        send_request(1'b0, OP_LOOKUP, 16'hFFFF, '1, '1, '1, 32'hFFFF_FFFF);
        send_request(1'b1, OP_LOOKUP, OPCODE_REPLY, 32'd0, 48'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        int          counted;
        int          items;
        bit          useful;
        logic [47:0] cfg_mac;
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_FRAME;
        arp_opcode = '0;
        sender_ip  = '0;
        sender_mac = '0;
        target_ip  = '0;
        lookup_ip  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_ip     = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;

        // Hold reset, then release it at a falling edge
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            // Pick register values: zeros and all ones among them
            case (phase)
                1: begin cfg_ip = '0; cfg_mac = '0; end
                2: begin cfg_ip = '1; cfg_mac = '1; end
                default: begin cfg_ip = $urandom; cfg_mac = rand_mac(); end
            endcase
            write_reg(REG_OWN_IP, {32'($urandom), cfg_ip});
            write_reg(REG_OWN_MAC, {16'($urandom), cfg_mac});
            if (phase == 0)
                run_directed();
            counted = 0;
            items   = 0;
            while (counted < PER_PHASE)
            begin
                // Pause mid-phase until the block has answered everything
                if (items == PER_PHASE / 2)
                    drain_results();
                // One phase runs without any start gaps
                send_random(phase != 2, useful);
                if (useful)
                    counted++;
                items++;
            end
        end

        drain_results();
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== arp_responder_and_cache_core.f =====
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_ram.sv
rtl/arc_front.sv
rtl/arc_back.sv
rtl/arp_responder_and_cache_core.sv
tb/arc_checker.sv
tb/tb.sv
